FILE: design/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [1:0] {
    CmdByte  = 2'd0,
    CmdFinal = 2'd1
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic       has_byte;
    logic [7:0] data;
  } req_t;

  typedef enum logic [2:0] {
    StIdle   = 3'd0,
    StPad    = 3'd1,
    StRound  = 3'd2,
    StAdd    = 3'd3,
    StOut    = 3'd4
  } back_state_e;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw = $clog2(QueueDepth);

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenPos = 6'd56;

  function automatic word_t ror(input word_t v, input int unsigned s);
    ror = (v >> s) | (v << (32 - s));
  endfunction

endpackage
`default_nettype wire

FILE: design/sha256_front.sv
`default_nettype none
// Classifies input items and pushes those with a byte or an end mark into a short request queue.
module sha256_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  output      logic               full_o,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic               has_byte_i,
  input  wire logic               end_of_message_i,
  input  wire logic               req_pop_i,
  output      logic               req_valid_o,
  output      sha256_pkg::req_t   req_o
);

  sha256_pkg::req_t mem_q [sha256_pkg::QueueDepth];
  logic [sha256_pkg::QueueAw-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [sha256_pkg::QueueAw:0]   cnt_q, cnt_d;
  logic wr_en, rd_en;
  sha256_pkg::req_t wr_req;

  // Items with neither a byte nor an end mark are dropped here.
  assign full_o = (cnt_q == (sha256_pkg::QueueAw+1)'(sha256_pkg::QueueDepth));
  assign wr_en  = push_i && !full_o && (has_byte_i || end_of_message_i);
  assign req_valid_o = (cnt_q != '0);
  assign rd_en  = req_pop_i && req_valid_o;
  assign req_o  = mem_q[rd_q];

  always_comb begin
    wr_req.data     = data_byte_i;
    wr_req.has_byte = has_byte_i;
    wr_req.cmd      = end_of_message_i ? sha256_pkg::CmdFinal : sha256_pkg::CmdByte;
    wr_d  = wr_en ? wr_q + 1'b1 : wr_q;
    rd_d  = rd_en ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + {{sha256_pkg::QueueAw{1'b0}}, wr_en} - {{sha256_pkg::QueueAw{1'b0}}, rd_en};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= wr_req;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

FILE: design/sha256_core.sv
`default_nettype none
// Packs bytes, pads, runs one round per cycle and emits the digest.
module sha256_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  input  wire sha256_pkg::req_t   req_i,
  output      logic               req_pop_o,
  output      logic               empty,
  input  wire logic               pop,
  output      logic [31:0]        digest_word_o,
  output      logic [2:0]         word_index_o,
  output      logic               last_word_o
);

  sha256_pkg::back_state_e state_q, state_d;
  sha256_pkg::word_t w_q [16];
  sha256_pkg::word_t h_q [8];
  sha256_pkg::word_t v_q [8];
  logic [5:0]  pos_q;
  logic [63:0] len_q;
  logic [5:0]  rnd_q;
  logic [2:0]  oidx_q;
  logic        fin_q;
  logic        padded_q;
  logic        lenblk_q;
  logic        pad_first;
  logic        len_write;
  logic        absorbing;
  logic        put_en;
  logic [7:0]  put_byte;
  logic        start_comp;
  sha256_pkg::word_t s0, s1, wnew, big0, big1, ch, maj, t1, t2;

  assign pad_first = (state_q == sha256_pkg::StPad) && !padded_q;
  assign len_write = (state_q == sha256_pkg::StPad) && (pos_q == sha256_pkg::LenPos - 6'd1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      sha256_pkg::StIdle: begin
        if (req_valid_i) begin
          if (req_i.has_byte && pos_q == 6'd63) begin
            state_d = sha256_pkg::StRound;
          end else if (req_i.cmd == sha256_pkg::CmdFinal) begin
            state_d = sha256_pkg::StPad;
          end
        end
      end
      sha256_pkg::StPad: begin
        if (pos_q == 6'd63 || pos_q == sha256_pkg::LenPos - 6'd1) begin
          state_d = sha256_pkg::StRound;
        end
      end
      sha256_pkg::StRound: begin
        if (rnd_q == 6'd63) state_d = sha256_pkg::StAdd;
      end
      sha256_pkg::StAdd: begin
        if (!fin_q) state_d = sha256_pkg::StIdle;
        else if (pos_q == '0 && lenblk_q) state_d = sha256_pkg::StOut;
        else state_d = sha256_pkg::StPad;
      end
      sha256_pkg::StOut: begin
        if (pop && oidx_q == 3'd7) state_d = sha256_pkg::StIdle;
      end
      default: state_d = sha256_pkg::StIdle;
    endcase
  end

  always_comb begin
    absorbing  = (state_q == sha256_pkg::StIdle) && req_valid_i;
    req_pop_o  = absorbing;
    put_en     = 1'b0;
    put_byte   = 8'h00;
    if (absorbing && req_i.has_byte) begin
      put_en   = 1'b1;
      put_byte = req_i.data;
    end else if (state_q == sha256_pkg::StPad) begin
      put_en   = 1'b1;
      put_byte = pad_first ? sha256_pkg::PadByte : 8'h00;
    end
    start_comp = (state_q != sha256_pkg::StRound) && (state_d == sha256_pkg::StRound);
    empty         = (state_q != sha256_pkg::StOut);
    digest_word_o = h_q[oidx_q];
    word_index_o  = oidx_q;
    last_word_o   = (oidx_q == 3'd7);
  end

  always_comb begin
    s0   = sha256_pkg::ror(w_q[1], 7) ^ sha256_pkg::ror(w_q[1], 18) ^ (w_q[1] >> 3);
    s1   = sha256_pkg::ror(w_q[14], 17) ^ sha256_pkg::ror(w_q[14], 19)
         ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0 + w_q[9] + s1;
    big1 = sha256_pkg::ror(v_q[4], 6) ^ sha256_pkg::ror(v_q[4], 11)
         ^ sha256_pkg::ror(v_q[4], 25);
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + big1 + ch + sha256_pkg::RoundK[rnd_q] + w_q[0];
    big0 = sha256_pkg::ror(v_q[0], 2) ^ sha256_pkg::ror(v_q[0], 13)
         ^ sha256_pkg::ror(v_q[0], 22);
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2   = big0 + maj;
  end

  always_ff @(posedge clk_i) begin
    if (put_en) begin
      if (pos_q[1:0] == 2'd0) begin
        w_q[pos_q[5:2]] <= {put_byte, 24'h0};
      end else begin
        w_q[pos_q[5:2]] <= w_q[pos_q[5:2]]
                         | ({24'h0, put_byte} << (6'd24 - {pos_q[1:0], 3'b000}));
      end
      if (len_write) begin
        w_q[14] <= len_q[63:32];
        w_q[15] <= len_q[31:0];
      end
    end else if (state_q == sha256_pkg::StRound) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
    end
    if (start_comp) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (state_q == sha256_pkg::StRound) begin
      v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sha256_pkg::StIdle;
      pos_q    <= '0;
      len_q    <= '0;
      rnd_q    <= '0;
      oidx_q   <= '0;
      fin_q    <= 1'b0;
      padded_q <= 1'b0;
      lenblk_q <= 1'b0;
      for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::InitH[i];
    end else begin
      state_q <= state_d;
      if (len_write) begin
        lenblk_q <= 1'b1;
        pos_q    <= '0;
      end else if (put_en) begin
        pos_q <= pos_q + 6'd1;
      end
      if (absorbing && req_i.has_byte) len_q <= len_q + 64'd8;
      if (absorbing && req_i.cmd == sha256_pkg::CmdFinal) fin_q <= 1'b1;
      if (pad_first) padded_q <= 1'b1;
      rnd_q <= (state_q == sha256_pkg::StRound) ? rnd_q + 6'd1 : 6'd0;
      if (state_q == sha256_pkg::StAdd) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (state_q == sha256_pkg::StOut && pop) begin
        oidx_q <= oidx_q + 3'd1;
        if (oidx_q == 3'd7) begin
          for (int i = 0; i < 8; i++) h_q[i] <= sha256_pkg::InitH[i];
          len_q    <= '0;
          pos_q    <= '0;
          fin_q    <= 1'b0;
          padded_q <= 1'b0;
          lenblk_q <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/sha256_hasher.sv
`default_nettype none
// Channel   Handshake           Payload
// input     push / full         data_byte_i, has_byte_i, end_of_message_i
// result    empty / pop         digest_word_o, word_index_o, last_word_o
// A byte is packed into the current block; a byte that fills a block starts
// the rounds and then the chain update. An end mark pads byte by byte and
// runs one or two compressions on the single round unit. A four-entry
// request queue keeps input open. Reset is asynchronous and active low;
// digest words wait until popped.
module sha256_hasher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output      logic        full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        has_byte_i,
  input  wire logic        end_of_message_i,
  output      logic        empty,
  input  wire logic        pop,
  output      logic [31:0] digest_word_o,
  output      logic [2:0]  word_index_o,
  output      logic        last_word_o
);

  logic             req_valid;
  logic             req_pop;
  sha256_pkg::req_t req;

  sha256_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full),
    .data_byte_i, .has_byte_i, .end_of_message_i,
    .req_pop_i(req_pop), .req_valid_o(req_valid), .req_o(req)
  );

  sha256_core u_core (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_i(req), .req_pop_o(req_pop),
    .empty, .pop, .digest_word_o, .word_index_o, .last_word_o
  );

endmodule
`default_nettype wire

FILE: design/sha256_checker.sv
`default_nettype none
module sha256_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [2:0]  word_index_o,
  input wire logic        last_word_o
);

  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_word_o == (word_index_o == 3'd7)))
    else $error("last word flag mismatch");

  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop) |=> (word_index_o == $past(word_index_o) + 3'd1))
    else $error("word index did not advance");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(word_index_o)))
    else $error("result withdrawn");

  a_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(empty) |-> (word_index_o == 3'd0))
    else $error("digest does not start at word zero");

endmodule

bind sha256_hasher sha256_checker u_checker (
  .clk_i, .rst_ni, .empty, .pop, .word_index_o, .last_word_o
);
`default_nettype wire
